// ===== src/rcppm_pkg.sv =====
package rcppm_pkg;

	localparam int MAX_CHANNELS_DEF = 16;

	localparam int US_W        = 16;
	localparam int COUNT_W     = 5;
	localparam int ELAPSED_W   = 21;
	localparam int FUNC_W      = 3;
	localparam int INDEX_W     = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PCT_W       = 7;
	localparam int PCT_FULL    = 100;
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = 24;
	localparam int S_DATA_W    = 24;
	localparam int M_DATA_W    = 24;

	localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = COUNT_W'(8);
	localparam logic               RST_INVERT        = 1'b0;
	localparam logic [US_W-1:0]    RST_PULSE_US      = US_W'(500);
	localparam logic [US_W-1:0]    RST_FRAME_US      = US_W'(22500);
	localparam logic [US_W-1:0]    RST_MIN_US        = US_W'(1000);
	localparam logic [US_W-1:0]    RST_MAX_US        = US_W'(2000);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_EVENT   = 3'd0,
		FUNC_SET_US  = 3'd1,
		FUNC_SET_PCT = 3'd2,
		FUNC_ENABLE  = 3'd3,
		FUNC_DISABLE = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT = 3'd0,
		CFG_INVERT_OUTPUT = 3'd1,
		CFG_PULSE_US      = 3'd2,
		CFG_FRAME_US      = 3'd3,
		CFG_MIN_US        = 3'd4,
		CFG_MAX_US        = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [COUNT_W-1:0] channel_count;
		logic               invert_output;
		logic [US_W-1:0]    pulse_us;
		logic [US_W-1:0]    frame_us;
		logic [US_W-1:0]    min_us;
		logic [US_W-1:0]    max_us;
	} cfg_t;

	typedef struct packed {
		logic               fire;
		func_t              func;
		logic [INDEX_W-1:0] channel_index;
	} item_t;

	// Entry p holds ceil(p * 2^23 / 100); multiplying a 16-bit span by it and
	// dropping 23 bits gives exactly floor(p * span / 100).
	typedef logic [RECIP_W-1:0] recip_tab_t [0:PCT_FULL];

	function automatic recip_tab_t build_recip();
		recip_tab_t t;
		for (int p = 0; p <= PCT_FULL; p++) begin
			t[p] = RECIP_W'((longint'(p) * (longint'(1) << RECIP_SHIFT) + PCT_FULL - 1)
				/ PCT_FULL);
		end
		return t;
	endfunction

	localparam recip_tab_t PCT_RECIP = build_recip();

endpackage

// ===== src/rcppm_setpoint.sv =====
module rcppm_setpoint (
	input  rcppm_pkg::cfg_t                      cfg,
	input  logic                                 is_pct,
	input  logic [rcppm_pkg::US_W-1:0]           value,
	input  logic [rcppm_pkg::RECIP_W-1:0]        recip,
	output logic [rcppm_pkg::US_W-1:0]           setpoint
);
	import rcppm_pkg::*;

	logic signed [US_W:0]       span;
	logic                       neg;
	logic [US_W-1:0]            mag;
	logic [US_W+RECIP_W-1:0]    prod;
	logic [US_W-1:0]            step;
	logic signed [US_W+1:0]     lo;
	logic signed [US_W+1:0]     hi;
	logic signed [US_W+1:0]     raw;

	always_comb begin
		span = $signed({1'b0, cfg.max_us}) - $signed({1'b0, cfg.min_us});
		neg  = span[US_W];
		mag  = neg ? US_W'(-span) : span[US_W-1:0];
		prod = (US_W+RECIP_W)'(mag) * (US_W+RECIP_W)'(recip);
		step = prod[RECIP_SHIFT +: US_W];
		lo   = $signed({2'b00, cfg.min_us});
		hi   = $signed({2'b00, cfg.max_us});
		if (is_pct) begin
			raw = neg ? lo - $signed({2'b00, step}) : lo + $signed({2'b00, step});
		end else begin
			raw = $signed({2'b00, value});
		end
		if (raw < lo) begin
			setpoint = cfg.min_us;
		end else if (raw > hi) begin
			setpoint = cfg.max_us;
		end else begin
			setpoint = raw[US_W-1:0];
		end
	end

endmodule

// ===== src/rcppm_core.sv =====
module rcppm_core #(
	parameter int MAX_CHANNELS = rcppm_pkg::MAX_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rcppm_pkg::cfg_t            cfg,
	input  rcppm_pkg::item_t           item,
	input  logic [rcppm_pkg::US_W-1:0] setpoint,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       pin_level,
	output logic [rcppm_pkg::US_W-1:0] interval_us,
	output logic                       frame_fill,
	output logic                       frame_overrun
);
	import rcppm_pkg::*;

	localparam int TW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW = $clog2(MAX_CHANNELS + 1);

	logic [US_W-1:0]         table_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] valid_q;
	logic                    phase_q;
	logic                    running_q;
	logic [CW-1:0]           counter_q;
	logic [ELAPSED_W-1:0]    elapsed_q;

	logic                    phase_d;
	logic                    running_d;
	logic [CW-1:0]           counter_d;
	logic [ELAPSED_W-1:0]    elapsed_d;

	logic                    out_valid_q;
	logic                    pin_q;
	logic [US_W-1:0]         interval_q;
	logic                    fill_q;
	logic                    over_q;

	logic                    res_valid;
	logic                    res_level;
	logic [US_W-1:0]         res_interval;
	logic                    res_fill;
	logic                    res_over;

	logic                    wr_en;
	logic [TW-1:0]           wr_idx;
	logic [TW-1:0]           rd_idx;
	logic [CW-1:0]           count;
	logic                    at_end;
	logic [US_W-1:0]         cv;
	logic [US_W-1:0]         gap;
	logic [US_W-1:0]         addend;
	logic [ELAPSED_W:0]      sum;
	logic [ELAPSED_W-1:0]    sum_sat;
	logic                    on_level;

	always_comb begin
		on_level = cfg.invert_output;
		count    = (int'(cfg.channel_count) > MAX_CHANNELS) ? CW'(MAX_CHANNELS)
			: CW'(cfg.channel_count);
		at_end   = (counter_q >= count);
		rd_idx   = counter_q[TW-1:0];
		cv       = valid_q[rd_idx] ? table_q[rd_idx] : RST_MIN_US;
		gap      = (cv > cfg.pulse_us) ? cv - cfg.pulse_us : '0;
		addend   = at_end ? cfg.pulse_us : cv;
		sum      = (ELAPSED_W+1)'(elapsed_q) + (ELAPSED_W+1)'(addend);
		sum_sat  = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		wr_idx   = TW'(item.channel_index);
	end

	always_comb begin
		res_valid    = 1'b0;
		res_level    = ~on_level;
		res_interval = '0;
		res_fill     = 1'b0;
		res_over     = 1'b0;
		phase_d      = phase_q;
		running_d    = running_q;
		counter_d    = counter_q;
		elapsed_d    = elapsed_q;
		wr_en        = 1'b0;
		if (item.fire) begin
			case (item.func)
				FUNC_EVENT: begin
					if (running_q) begin
						res_valid = 1'b1;
						phase_d   = ~phase_q;
						if (phase_q) begin
							res_level    = on_level;
							res_interval = cfg.pulse_us;
						end else if (at_end) begin
							res_fill  = 1'b1;
							counter_d = '0;
							elapsed_d = '0;
							if (sum_sat > ELAPSED_W'(cfg.frame_us)) begin
								res_over = 1'b1;
							end else begin
								res_interval = cfg.frame_us - sum_sat[US_W-1:0];
							end
						end else begin
							res_interval = gap;
							elapsed_d    = sum_sat;
							counter_d    = counter_q + CW'(1);
						end
					end
				end
				FUNC_SET_US, FUNC_SET_PCT: begin
					wr_en = (int'(item.channel_index) < MAX_CHANNELS);
				end
				FUNC_ENABLE: begin
					running_d = 1'b1;
				end
				FUNC_DISABLE: begin
					res_valid = 1'b1;
					running_d = 1'b0;
					phase_d   = 1'b0;
					counter_d = '0;
					elapsed_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_idx] <= setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			phase_q   <= 1'b1;
			running_q <= 1'b1;
			counter_q <= '0;
			elapsed_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			phase_q   <= phase_d;
			running_q <= running_d;
			counter_q <= counter_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			pin_q      <= res_level;
			interval_q <= res_interval;
			fill_q     <= res_fill;
			over_q     <= res_over;
		end
	end

	assign out_valid     = out_valid_q;
	assign pin_level     = pin_q;
	assign interval_us   = interval_q;
	assign frame_fill    = fill_q;
	assign frame_overrun = over_q;

endmodule

// ===== src/rc_ppm_pulse_train_encoder.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: channel_index, value
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pin_level, interval_us;
//                                                     tlast: frame_fill; tuser: frame_overrun
// cfg       in         cfg_wr_en                      cfg_index, cfg_wdata
//
// One word is accepted every cycle while the output does not stall; its result, if any, is
// held in the result register. The input register and the result register each hold one word,
// and the state update (table read, subtract, saturating add, toggle) happens between them.
// A stalled output holds the result register and, once the input register is full, the input.
// Reset is asynchronous and restores the configuration defaults and the table contents at once.
module rc_ppm_pulse_train_encoder #(
	parameter int MAX_CHANNELS = rcppm_pkg::MAX_CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [rcppm_pkg::S_DATA_W-1:0]     s_axis_tdata,   // channel_index, value
	input  logic [rcppm_pkg::FUNC_W-1:0]       s_axis_tuser,   // func
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [rcppm_pkg::M_DATA_W-1:0]     m_axis_tdata,   // pin_level, interval_us
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser,   // frame_overrun
	input  logic                               cfg_wr_en,
	input  logic [rcppm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcppm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rcppm_pkg::*;

	cfg_t                cfg_q;
	logic                valid_s1;
	func_t               func_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [US_W-1:0]     value_s1;
	logic [RECIP_W-1:0]  recip_s1;
	logic                advance;
	logic [PCT_W-1:0]    pct;
	item_t               item;
	logic [US_W-1:0]     setpoint;
	logic                pin_level;
	logic [US_W-1:0]     interval_us;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
			cfg_q.invert_output <= RST_INVERT;
			cfg_q.pulse_us      <= RST_PULSE_US;
			cfg_q.frame_us      <= RST_FRAME_US;
			cfg_q.min_us        <= RST_MIN_US;
			cfg_q.max_us        <= RST_MAX_US;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[COUNT_W-1:0];
				CFG_INVERT_OUTPUT: cfg_q.invert_output <= cfg_wdata[0];
				CFG_PULSE_US:      cfg_q.pulse_us      <= cfg_wdata[US_W-1:0];
				CFG_FRAME_US:      cfg_q.frame_us      <= cfg_wdata[US_W-1:0];
				CFG_MIN_US:        cfg_q.min_us        <= cfg_wdata[US_W-1:0];
				CFG_MAX_US:        cfg_q.max_us        <= cfg_wdata[US_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		pct = (s_axis_tdata[INDEX_W +: US_W] > US_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
			: s_axis_tdata[INDEX_W +: PCT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1  <= func_t'(s_axis_tuser);
			index_s1 <= s_axis_tdata[INDEX_W-1:0];
			value_s1 <= s_axis_tdata[INDEX_W +: US_W];
			recip_s1 <= PCT_RECIP[pct];
		end
	end

	always_comb begin
		item.fire          = advance;
		item.func          = func_s1;
		item.channel_index = index_s1;
	end

	rcppm_setpoint u_setpoint (
		.cfg      (cfg_q),
		.is_pct   (func_s1 == FUNC_SET_PCT),
		.value    (value_s1),
		.recip    (recip_s1),
		.setpoint (setpoint)
	);

	rcppm_core #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item          (item),
		.setpoint      (setpoint),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.pin_level     (pin_level),
		.interval_us   (interval_us),
		.frame_fill    (m_axis_tlast),
		.frame_overrun (m_axis_tuser)
	);

	assign m_axis_tdata = {(M_DATA_W-US_W-1)'(0), interval_us, pin_level};

endmodule

// ===== tb/tb_rc_ppm_pulse_train_encoder.sv =====
module tb_rc_ppm_pulse_train_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import rcppm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ITEMS    = 135;
	localparam int MAX_REPORTS    = 100;
	localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

	typedef struct packed {
		logic            pin;
		logic [US_W-1:0] interval;
		logic            fill;
		logic            overrun;
	} ppm_word_t;

	typedef enum {PROFILE_TYPICAL, PROFILE_FLOOR, PROFILE_CEILING, PROFILE_WILD} profile_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
	logic [FUNC_W-1:0]     s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

	cfg_t                  cur_cfg;
	logic [US_W-1:0]       chan_us [MAX_CHANNELS_DEF];
	logic                  pulse_next;
	logic [COUNT_W-1:0]    chan_pos;
	logic [ELAPSED_W-1:0]  elapsed;
	logic                  enabled;
	ppm_word_t             due_intervals [$];

	int                    mismatch_count = 0;
	bit                    gaps_on = 1'b1;
	bit                    hold_req = 1'b0;

	rc_ppm_pulse_train_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [ELAPSED_W-1:0] sat_add(logic [ELAPSED_W-1:0] a, logic [US_W-1:0] b);
		logic [ELAPSED_W:0] sum;
		sum = a + b;
		return (sum > ELAPSED_SAT) ? ELAPSED_SAT : sum[ELAPSED_W-1:0];
	endfunction

	function automatic logic [US_W-1:0] clamp_us(longint v);
		if (v < longint'(cur_cfg.min_us)) return cur_cfg.min_us;
		if (v > longint'(cur_cfg.max_us)) return cur_cfg.max_us;
		return US_W'(v);
	endfunction

	function automatic void encode_item(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
		logic [US_W-1:0] val);
		ppm_word_t          w;
		logic [COUNT_W-1:0] n_chan;
		logic [US_W-1:0]    cv;
		longint             pct;
		longint             span;
		w = '0;
		case (func)
		FUNC_EVENT: begin
			if (enabled) begin
				n_chan = (cur_cfg.channel_count > MAX_CHANNELS_DEF) ?
					COUNT_W'(MAX_CHANNELS_DEF) : cur_cfg.channel_count;
				if (pulse_next) begin
					w.pin = cur_cfg.invert_output;
					w.interval = cur_cfg.pulse_us;
				end else begin
					w.pin = ~cur_cfg.invert_output;
					if (chan_pos >= n_chan) begin
						chan_pos = '0;
						elapsed = sat_add(elapsed, cur_cfg.pulse_us);
						w.fill = 1'b1;
						if (elapsed > cur_cfg.frame_us) begin
							w.overrun = 1'b1;
						end else begin
							w.interval = US_W'(cur_cfg.frame_us - elapsed);
						end
						elapsed = '0;
					end else begin
						cv = chan_us[chan_pos];
						w.interval = (cv > cur_cfg.pulse_us) ? cv - cur_cfg.pulse_us : '0;
						elapsed = sat_add(elapsed, cv);
						chan_pos = chan_pos + 1'b1;
					end
				end
				pulse_next = ~pulse_next;
				due_intervals.push_back(w);
			end
		end
		FUNC_SET_US: begin
			if (idx < MAX_CHANNELS_DEF) chan_us[idx] = clamp_us(longint'(val));
		end
		FUNC_SET_PCT: begin
			if (idx < MAX_CHANNELS_DEF) begin
				pct = (val > PCT_FULL) ? PCT_FULL : longint'(val);
				span = longint'(cur_cfg.max_us) - longint'(cur_cfg.min_us);
				chan_us[idx] = clamp_us(longint'(cur_cfg.min_us) + (pct * span) / PCT_FULL);
			end
		end
		FUNC_ENABLE: begin
			enabled = 1'b1;
		end
		FUNC_DISABLE: begin
			enabled = 1'b0;
			pulse_next = 1'b0;
			elapsed = '0;
			chan_pos = '0;
			w.pin = ~cur_cfg.invert_output;
			due_intervals.push_back(w);
		end
		default: begin
		end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic cfg_t pick_cfg(profile_t kind);
		cfg_t c;
		case (kind)
		PROFILE_FLOOR: begin
			c = '0;
			c.channel_count = COUNT_W'(1);
		end
		PROFILE_CEILING: begin
			c = '1;
		end
		PROFILE_WILD: begin
			c.channel_count = COUNT_W'($urandom);
			c.invert_output = 1'($urandom);
			c.pulse_us      = US_W'($urandom);
			c.frame_us      = US_W'($urandom);
			c.min_us        = US_W'($urandom);
			c.max_us        = US_W'($urandom);
		end
		default: begin
			c.channel_count = COUNT_W'($urandom_range(1, MAX_CHANNELS_DEF));
			c.invert_output = 1'($urandom);
			c.pulse_us      = US_W'($urandom_range(250, 500));
			c.frame_us      = US_W'($urandom_range(5000, 40000));
			c.min_us        = US_W'($urandom_range(900, 1100));
			c.max_us        = US_W'($urandom_range(1900, 2100));
		end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic send_word(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
		input logic [US_W-1:0] val);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= S_DATA_W'({val, idx});
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		encode_item(func, idx, val);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (due_intervals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_apply(input cfg_t c);
		logic [CFG_DATA_W-1:0] noise;
		for (int i = 0; i < 2**CFG_IDX_W; i++) begin
			noise = CFG_DATA_W'($urandom);
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			case (cfg_index_t'(i))
			CFG_CHANNEL_COUNT: cfg_wdata <= {noise[CFG_DATA_W-1:COUNT_W], c.channel_count};
			CFG_INVERT_OUTPUT: cfg_wdata <= {noise[CFG_DATA_W-1:1], c.invert_output};
			CFG_PULSE_US:      cfg_wdata <= c.pulse_us;
			CFG_FRAME_US:      cfg_wdata <= c.frame_us;
			CFG_MIN_US:        cfg_wdata <= c.min_us;
			CFG_MAX_US:        cfg_wdata <= c.max_us;
			default:           cfg_wdata <= noise;
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic run_random(input int target);
		int                useful;
		int                r;
		logic [FUNC_W-1:0] func;
		logic [US_W-1:0]   val;
		useful = 0;
		while (useful < target) begin
			r = $urandom_range(0, 99);
			val = US_W'($urandom);
			if (r < 60) begin
				func = FUNC_EVENT;
			end else if (r < 74) begin
				func = FUNC_SET_US;
				if ($urandom_range(0, 1))
					val = US_W'($urandom_range(cur_cfg.min_us, cur_cfg.max_us));
			end else if (r < 86) begin
				func = FUNC_SET_PCT;
				if ($urandom_range(0, 4) != 0) val = US_W'($urandom_range(0, PCT_FULL));
			end else if (r < 93) begin
				func = FUNC_ENABLE;
			end else if (r < 96) begin
				func = FUNC_DISABLE;
			end else begin
				func = FUNC_W'($urandom_range(int'(FUNC_DISABLE) + 1, 2**FUNC_W - 1));
			end
			if ((func == FUNC_EVENT) ? enabled : (func <= FUNC_DISABLE)) useful++;
			send_word(func, INDEX_W'($urandom), val);
		end
	endtask

	task automatic test_reset_defaults();
		repeat (4) send_word(FUNC_EVENT, '0, '0);
		settle();
	endtask

	task automatic test_channel_writes();
		cfg_t c;
		c = cur_cfg;
		c.channel_count = COUNT_W'(2);
		c.invert_output = 1'b1;
		c.pulse_us      = US_W'(1500);
		c.frame_us      = US_W'(3000);
		c.min_us        = US_W'(1000);
		c.max_us        = US_W'(2000);
		cfg_apply(c);
		send_word(FUNC_SET_US, INDEX_W'(0), '0);
		send_word(FUNC_SET_US, INDEX_W'(1), '1);
		send_word(FUNC_SET_PCT, '1, '1);
		send_word(FUNC_SET_PCT, INDEX_W'(2), '0);
		send_word(FUNC_SET_PCT, INDEX_W'(0), US_W'(37));
		for (int f = int'(FUNC_DISABLE) + 1; f < 2**FUNC_W; f++)
			send_word(FUNC_W'(f), '1, '1);
		repeat (6) send_word(FUNC_EVENT, '0, '0);
		settle();
	endtask

	task automatic test_enable_disable();
		send_word(FUNC_DISABLE, '0, '0);
		send_word(FUNC_EVENT, '0, '0);
		send_word(FUNC_ENABLE, '0, '0);
		send_word(FUNC_EVENT, '0, '0);
		settle();
	endtask

	task automatic test_empty_frame();
		cfg_t c;
		c = cur_cfg;
		c.channel_count = '0;
		cfg_apply(c);
		repeat (2) send_word(FUNC_EVENT, '0, '0);
		settle();
	endtask

	task automatic test_reversed_range();
		cfg_t c;
		c = cur_cfg;
		c.channel_count = COUNT_W'(1);
		c.min_us        = US_W'(3000);
		c.max_us        = US_W'(1013);
		cfg_apply(c);
		send_word(FUNC_SET_PCT, INDEX_W'(0), US_W'(41));
		repeat (2) send_word(FUNC_EVENT, '0, '0);
		settle();
	endtask

	task automatic test_random_profiles();
		profile_t plan [10];
		plan = '{PROFILE_TYPICAL, PROFILE_FLOOR, PROFILE_TYPICAL, PROFILE_CEILING, PROFILE_WILD,
			PROFILE_TYPICAL, PROFILE_WILD, PROFILE_TYPICAL, PROFILE_WILD, PROFILE_TYPICAL};
		for (int i = 0; i < 10; i++) begin
			gaps_on = (i % 3 != 2);
			cfg_apply(pick_cfg(plan[i]));
			send_word(FUNC_ENABLE, '0, '0);
			run_random(PHASE_ITEMS);
			settle();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		cfg_apply(pick_cfg(PROFILE_TYPICAL));
		send_word(FUNC_ENABLE, '0, '0);
		hold_req = 1'b1;
		repeat (40) send_word(FUNC_EVENT, '0, '0);
		settle();
		gaps_on = 1'b1;
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && gaps_on && $urandom_range(0, 2) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		ppm_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_intervals.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata, 0);
			end else begin
				want = due_intervals.pop_front();
				if (m_axis_tdata[0] !== want.pin)
					report_mismatch("pin_level", m_axis_tdata[0], want.pin);
				if (m_axis_tdata[US_W:1] !== want.interval)
					report_mismatch("interval_us", m_axis_tdata[US_W:1], want.interval);
				if (m_axis_tlast !== want.fill)
					report_mismatch("frame_fill", m_axis_tlast, want.fill);
				if (m_axis_tuser !== want.overrun)
					report_mismatch("frame_overrun", m_axis_tuser, want.overrun);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		cur_cfg.channel_count = RST_CHANNEL_COUNT;
		cur_cfg.invert_output = RST_INVERT;
		cur_cfg.pulse_us      = RST_PULSE_US;
		cur_cfg.frame_us      = RST_FRAME_US;
		cur_cfg.min_us        = RST_MIN_US;
		cur_cfg.max_us        = RST_MAX_US;
		for (int i = 0; i < MAX_CHANNELS_DEF; i++) chan_us[i] = RST_MIN_US;
		pulse_next = 1'b1;
		chan_pos   = '0;
		elapsed    = '0;
		enabled    = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_channel_writes();
		test_enable_disable();
		test_empty_frame();
		test_reversed_range();
		test_backpressure();
		test_random_profiles();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
